/* src/wdq_pkg.sv */
// ----------------------------------------------------------------------------
// wdq_pkg
// Shared widths, opcodes and status codes for the watermark dedup queue.
// ----------------------------------------------------------------------------
`default_nettype none

package wdq_pkg;

  // Field widths
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PEND_W   = 5;
  localparam int unsigned ENTRY_W  = EPOCH_W + TAG_W;

  // Opcodes
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_MARK  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED    = 3'd0,
    ST_STALE     = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLOSED    = 3'd4,
    ST_MARKED    = 3'd5
  } status_e;

endpackage

`default_nettype wire

/* src/wdq_if.sv */
// ----------------------------------------------------------------------------
// wdq_if
// Valid/ready channels for operations in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wdq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [wdq_pkg::EPOCH_W-1:0]  item_epoch;
  logic [wdq_pkg::TAG_W-1:0]    item_tag;
  logic                         last_in_batch;

  modport source (output valid, opcode, item_epoch, item_tag, last_in_batch,
                  input ready);
  modport sink   (input valid, opcode, item_epoch, item_tag, last_in_batch,
                  output ready);
endinterface

interface wdq_out_if;
  logic                         valid;
  logic                         ready;
  logic [wdq_pkg::STATUS_W-1:0] status;
  logic                         head_valid;
  logic [wdq_pkg::EPOCH_W-1:0]  head_epoch;
  logic [wdq_pkg::TAG_W-1:0]    head_tag;
  logic [wdq_pkg::PEND_W-1:0]   pending_count;

  modport source (output valid, status, head_valid, head_epoch, head_tag,
                  pending_count, input ready);
  modport sink   (input valid, status, head_valid, head_epoch, head_tag,
                  pending_count, output ready);
endinterface

`default_nettype wire

/* src/wdq_store.sv */
// ----------------------------------------------------------------------------
// wdq_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wdq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* src/watermark_dedup_queue.sv */
// ----------------------------------------------------------------------------
// watermark_dedup_queue
// Timestamped entry queue with a high-water mark, duplicate filter and
// compaction of shown entries, built around a single entry memory.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  in_i     in   valid/ready   opcode, item_epoch, item_tag, last_in_batch
//  out_o    out  valid/ready   status, head_valid, head_epoch, head_tag,
//                              pending_count
//
// One operation at a time; a transfer on in_i happens only in idle.
// A mark and a stale or closed offer go straight to the head read. Other
// offers scan the pending entries for a duplicate through the memory read
// port; a full queue with shown entries is compacted before the append.
// A result waiting on out_o does not block the next input transfer; a stall
// holds the sequencer only when the next result is ready to load.
// Reset clears all control state; the memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module watermark_dedup_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  wdq_in_if.sink   in_i,
  wdq_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_APPEND,
    S_HEAD_RD,
    S_HEAD_WAIT
  } state_e;

  state_e                     state_q, state_d;
  logic [wdq_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic [wdq_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic                       last_q, last_d;
  wdq_pkg::status_e           status_q, status_d;
  logic [wdq_pkg::EPOCH_W-1:0] wm_q, wm_d;
  logic [CNT_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic                       closed_q, closed_d;
  logic [CNT_W-1:0]           ptr_q, ptr_d;
  logic [IDX_W-1:0]           wptr_q, wptr_d;
  logic                       pend_q, pend_d;

  logic                       out_valid_q, out_valid_d;
  logic [wdq_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                       out_hvalid_q, out_hvalid_d;
  logic [wdq_pkg::EPOCH_W-1:0] out_epoch_q, out_epoch_d;
  logic [wdq_pkg::TAG_W-1:0]  out_tag_q, out_tag_d;
  logic [wdq_pkg::PEND_W-1:0] out_pend_q, out_pend_d;

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [wdq_pkg::ENTRY_W-1:0] wr_data;
  logic [wdq_pkg::ENTRY_W-1:0] rd_data;
  logic [wdq_pkg::EPOCH_W-1:0] rd_epoch;
  logic [wdq_pkg::TAG_W-1:0]  rd_tag;

  logic                       out_free;
  logic                       scan_hit;
  logic [CNT_W-1:0]           mark_head;
  logic                       head_live;
  logic [CNT_W-1:0]           pend_cnt;

  // Entry memory
  wdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (wdq_pkg::ENTRY_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_epoch = rd_data[wdq_pkg::ENTRY_W-1:wdq_pkg::TAG_W];
  assign rd_tag   = rd_data[wdq_pkg::TAG_W-1:0];

  assign out_free  = !out_valid_q || out_o.ready;
  assign scan_hit  = pend_q && (rd_epoch == epoch_q);
  assign mark_head = (head_q < fill_q) ? (head_q + CNT_ONE) : head_q;
  assign head_live = head_q < fill_q;
  assign pend_cnt  = fill_q - head_q;

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    epoch_d      = epoch_q;
    tag_d        = tag_q;
    last_d       = last_q;
    status_d     = status_q;
    wm_d         = wm_q;
    head_d       = head_q;
    fill_d       = fill_q;
    closed_d     = closed_q;
    ptr_d        = ptr_q;
    wptr_d       = wptr_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_hvalid_d = out_hvalid_q;
    out_epoch_d  = out_epoch_q;
    out_tag_d    = out_tag_q;
    out_pend_d   = out_pend_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = wptr_q;
    wr_data      = rd_data;

    // result register drains on a transfer
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          epoch_d = in_i.item_epoch;
          tag_d   = in_i.item_tag;
          last_d  = in_i.last_in_batch;
          if (in_i.opcode == wdq_pkg::OP_MARK) begin
            status_d = wdq_pkg::ST_MARKED;
            if (in_i.item_epoch > wm_q) begin
              wm_d = in_i.item_epoch;
            end
            if (mark_head >= fill_q) begin
              head_d = '0;
              fill_d = '0;
            end else begin
              head_d = mark_head;
            end
            state_d = S_HEAD_RD;
          end else if (closed_q) begin
            status_d = wdq_pkg::ST_CLOSED;
            if (in_i.last_in_batch) closed_d = 1'b0;
            state_d = S_HEAD_RD;
          end else if (in_i.item_epoch <= wm_q) begin
            status_d = wdq_pkg::ST_STALE;
            if (in_i.last_in_batch) closed_d = 1'b0;
            state_d = S_HEAD_RD;
          end else begin
            ptr_d   = head_q;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      // walk the pending entries, one read issued per cycle
      S_SCAN: begin
        if (scan_hit) begin
          status_d = wdq_pkg::ST_DUPLICATE;
          if (last_q) closed_d = 1'b0;
          pend_d  = 1'b0;
          state_d = S_HEAD_RD;
        end else if (ptr_q < fill_q) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + CNT_ONE;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (fill_q == CNT_FULL) begin
            if (head_q == '0) begin
              status_d = wdq_pkg::ST_FULL;
              closed_d = !last_q;
              state_d  = S_HEAD_RD;
            end else begin
              ptr_d   = head_q;
              wptr_d  = '0;
              state_d = S_COMPACT;
            end
          end else begin
            state_d = S_APPEND;
          end
        end
      end

      // move pending entries down to the base; each write trails its registered read
      S_COMPACT: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = wptr_q;
          wr_data = rd_data;
          wptr_d  = wptr_q + IDX_ONE;
        end
        if (ptr_q < fill_q) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + CNT_ONE;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            fill_d  = fill_q - head_q;
            head_d  = '0;
            state_d = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        wr_en    = 1'b1;
        wr_addr  = fill_q[IDX_W-1:0];
        wr_data  = {epoch_q, tag_q};
        fill_d   = fill_q + CNT_ONE;
        status_d = wdq_pkg::ST_QUEUED;
        if (last_q) closed_d = 1'b0;
        state_d  = S_HEAD_RD;
      end

      S_HEAD_RD: begin
        rd_en   = 1'b1;
        rd_addr = head_q[IDX_W-1:0];
        state_d = S_HEAD_WAIT;
      end

      // load the result once the output register is free
      S_HEAD_WAIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_hvalid_d = head_live;
          out_epoch_d  = head_live ? rd_epoch : '0;
          out_tag_d    = head_live ? rd_tag : '0;
          out_pend_d   = wdq_pkg::PEND_W'(pend_cnt);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      epoch_q      <= '0;
      tag_q        <= '0;
      last_q       <= 1'b0;
      status_q     <= wdq_pkg::ST_QUEUED;
      wm_q         <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      closed_q     <= 1'b0;
      ptr_q        <= '0;
      wptr_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_hvalid_q <= 1'b0;
      out_epoch_q  <= '0;
      out_tag_q    <= '0;
      out_pend_q   <= '0;
    end else begin
      state_q      <= state_d;
      epoch_q      <= epoch_d;
      tag_q        <= tag_d;
      last_q       <= last_d;
      status_q     <= status_d;
      wm_q         <= wm_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      closed_q     <= closed_d;
      ptr_q        <= ptr_d;
      wptr_q       <= wptr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_hvalid_q <= out_hvalid_d;
      out_epoch_q  <= out_epoch_d;
      out_tag_q    <= out_tag_d;
      out_pend_q   <= out_pend_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.head_valid    = out_hvalid_q;
  assign out_o.head_epoch    = out_epoch_q;
  assign out_o.head_tag      = out_tag_q;
  assign out_o.pending_count = out_pend_q;

endmodule

`default_nettype wire

/* bench/tb_watermark_dedup_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_watermark_dedup_queue
// Self-checking bench for the watermark dedup queue. A shadow model of the
// entry store, head, fill, watermark and batch-close flag predicts every
// result. Directed tests cover stale, duplicate, full, closed-batch and
// compaction cases. Random batches of offers and marks run with random gaps
// on both channels and one long output stall.
// ----------------------------------------------------------------------------

module tb_watermark_dedup_queue;

  localparam int unsigned QD         = 16;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned DRAIN_WAIT = 64;
  localparam int unsigned CYCLE_CAP  = 600000;

  typedef struct packed {
    wdq_pkg::status_e              status;
    logic                          head_valid;
    logic [wdq_pkg::EPOCH_W-1:0]   head_epoch;
    logic [wdq_pkg::TAG_W-1:0]     head_tag;
    logic [wdq_pkg::PEND_W-1:0]    pending;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  wdq_in_if  in_if ();
  wdq_out_if out_if ();

  watermark_dedup_queue #(
    .QUEUE_DEPTH(QD)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow copy of the queue state
  logic [wdq_pkg::EPOCH_W-1:0] shadow_epoch [QD];
  logic [wdq_pkg::TAG_W-1:0]   shadow_tag   [QD];
  int unsigned                 shadow_head;
  int unsigned                 shadow_fill;
  logic [wdq_pkg::EPOCH_W-1:0] shadow_wm;
  bit                          shadow_closed;

  outcome_t                    awaited_outcomes [$];
  int unsigned                 err_cnt;
  int unsigned                 sent_cnt;
  int unsigned                 checked_cnt;
  int unsigned                 status_hits [6];
  int unsigned                 cycle_cnt;
  logic [wdq_pkg::EPOCH_W-1:0] epoch_cursor;

  // Idle control shared between test tasks and the result sink
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_tog;
  bit          hold_seen;
  int unsigned hold_cnt;
  int unsigned rx_wait;

  // Clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Apply one operation to the shadow state and return the expected result
  function automatic outcome_t predict_queue_op(logic op, logic [wdq_pkg::EPOCH_W-1:0] e,
                                                logic [wdq_pkg::TAG_W-1:0] tag,
                                                logic last);
    outcome_t         res;
    wdq_pkg::status_e st;
    bit               seen;
    if (op == wdq_pkg::OP_OFFER) begin
      seen = 1'b0;
      for (int unsigned j = shadow_head; j < shadow_fill; j++)
        if (shadow_epoch[j] == e) seen = 1'b1;
      if (shadow_closed) begin
        st = wdq_pkg::ST_CLOSED;
      end else if (e <= shadow_wm) begin
        st = wdq_pkg::ST_STALE;
      end else if (seen) begin
        st = wdq_pkg::ST_DUPLICATE;
      end else begin
        st = wdq_pkg::ST_QUEUED;
        if (shadow_fill >= QD) begin
          if (shadow_head == 0) begin
            st = wdq_pkg::ST_FULL;
            shadow_closed = 1'b1;
          end else begin
            // squeeze shown entries out of the store
            for (int unsigned j = shadow_head; j < shadow_fill; j++) begin
              shadow_epoch[j - shadow_head] = shadow_epoch[j];
              shadow_tag[j - shadow_head]   = shadow_tag[j];
            end
            shadow_fill = shadow_fill - shadow_head;
            shadow_head = 0;
          end
        end
        if (st == wdq_pkg::ST_QUEUED && shadow_fill < QD) begin
          shadow_epoch[shadow_fill] = e;
          shadow_tag[shadow_fill]   = tag;
          shadow_fill++;
        end
      end
      if (last) shadow_closed = 1'b0;
    end else begin
      st = wdq_pkg::ST_MARKED;
      if (e > shadow_wm) shadow_wm = e;
      if (shadow_head < shadow_fill) shadow_head++;
      if (shadow_head >= shadow_fill) begin
        shadow_head = 0;
        shadow_fill = 0;
      end
    end
    res.status     = st;
    res.head_valid = (shadow_head < shadow_fill);
    res.head_epoch = res.head_valid ? shadow_epoch[shadow_head] : '0;
    res.head_tag   = res.head_valid ? shadow_tag[shadow_head] : '0;
    res.pending    = wdq_pkg::PEND_W'(shadow_fill - shadow_head);
    return res;
  endfunction

  // Send one operation; returns at the edge of its transfer
  task automatic issue_op(logic op, logic [wdq_pkg::EPOCH_W-1:0] e,
                          logic [wdq_pkg::TAG_W-1:0] tag, logic last);
    int unsigned gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.item_epoch    <= e;
    in_if.item_tag      <= tag;
    in_if.last_in_batch <= last;
    do @(posedge clk_i); while (!in_if.ready);
    awaited_outcomes.push_back(predict_queue_op(op, e, tag, last));
    sent_cnt++;
  endtask

  // Offer with a fresh epoch most of the time, else a duplicate, stale or wild one
  task automatic offer_entry(logic last);
    logic [wdq_pkg::EPOCH_W-1:0] e;
    int unsigned                 pick;
    int unsigned                 pend;
    pick = $urandom_range(0, 23);
    pend = shadow_fill - shadow_head;
    if (pick < 2 && pend > 0) begin
      e = shadow_epoch[shadow_head + $urandom_range(0, pend - 1)];
    end else if (pick == 2) begin
      e = $urandom_range(0, shadow_wm);
    end else if (pick == 3) begin
      e = $urandom;
    end else begin
      if (epoch_cursor < shadow_wm) epoch_cursor = shadow_wm;
      epoch_cursor = epoch_cursor + $urandom_range(1, 40);
      e = epoch_cursor;
    end
    issue_op(wdq_pkg::OP_OFFER, e, wdq_pkg::TAG_W'($urandom), last);
  endtask

  // Mark the head shown; keep the watermark away from the top of the range
  task automatic mark_head();
    logic [wdq_pkg::EPOCH_W-1:0] e;
    logic [wdq_pkg::EPOCH_W-1:0] he;
    he = shadow_epoch[shadow_head];
    if (shadow_head < shadow_fill && he > shadow_wm && he - shadow_wm < 32'h0010_0000)
      e = he;
    else if ($urandom_range(0, 3) == 0)
      e = $urandom_range(0, shadow_wm);
    else
      e = shadow_wm;
    issue_op(wdq_pkg::OP_MARK, e, wdq_pkg::TAG_W'($urandom), 1'($urandom));
  endtask

  // Result sink: per-transfer gaps plus one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned rx_gap;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait      <= 0;
      hold_cnt     <= 0;
      hold_seen    <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen    <= hold_tog;
      hold_cnt     <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_if.ready <= (hold_cnt == 1);
    end else if (out_if.valid && out_if.ready) begin
      rx_gap        = draw_gap(rx_calm);
      rx_wait      <= rx_gap;
      out_if.ready <= (rx_gap == 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      out_if.ready <= (rx_wait == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, out_if.status);
        err_cnt++;
      end else begin
        want = awaited_outcomes.pop_front();
        checked_cnt++;
        if (out_if.status < 6) status_hits[out_if.status]++;
        if (out_if.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, out_if.status);
          err_cnt++;
        end
        if (out_if.head_valid !== want.head_valid) begin
          $display("%0t: head_valid exp %0d got %0d", $time, want.head_valid,
                   out_if.head_valid);
          err_cnt++;
        end
        if (out_if.head_epoch !== want.head_epoch) begin
          $display("%0t: head_epoch exp %h got %h", $time, want.head_epoch,
                   out_if.head_epoch);
          err_cnt++;
        end
        if (out_if.head_tag !== want.head_tag) begin
          $display("%0t: head_tag exp %h got %h", $time, want.head_tag, out_if.head_tag);
          err_cnt++;
        end
        if (out_if.pending_count !== want.pending) begin
          $display("%0t: pending_count exp %0d got %0d", $time, want.pending,
                   out_if.pending_count);
          err_cnt++;
        end
      end
    end
  end

  // Empty-queue mark, stale, duplicate and drain-to-empty
  task automatic test_basic_ops();
    issue_op(wdq_pkg::OP_MARK,  32'd0, 16'h0000, 1'b0);
    issue_op(wdq_pkg::OP_OFFER, 32'd0, 16'h1234, 1'b1);
    issue_op(wdq_pkg::OP_OFFER, 32'd1, 16'hFFFF, 1'b1);
    issue_op(wdq_pkg::OP_OFFER, 32'd1, 16'h0000, 1'b0);
    issue_op(wdq_pkg::OP_MARK,  32'd0, 16'hFFFF, 1'b1);
  endtask

  // Fill the store with nothing shown, then hit full and closed-batch drops
  task automatic test_full_and_batch_close();
    for (int unsigned k = 0; k < QD - 1; k++)
      issue_op(wdq_pkg::OP_OFFER, 32'd10 + k, wdq_pkg::TAG_W'($urandom), 1'b0);
    issue_op(wdq_pkg::OP_OFFER, 32'hFFFF_FFFE, 16'hFFFF, 1'b0);
    issue_op(wdq_pkg::OP_OFFER, 32'd200, 16'h0001, 1'b0);   // full, closes the batch
    issue_op(wdq_pkg::OP_OFFER, 32'd201, 16'h0002, 1'b1);   // dropped, reopens
    issue_op(wdq_pkg::OP_OFFER, 32'd500, 16'h0003, 1'b1);   // full, batch stays open
  endtask

  // One shown entry lets the next offer compact the store
  task automatic test_compaction();
    issue_op(wdq_pkg::OP_MARK,  32'd10, 16'h5A5A, 1'b0);
    issue_op(wdq_pkg::OP_OFFER, 32'd30, 16'hA5A5, 1'b1);
  endtask

  // Random batches: mostly well-formed, some noise and overfill bursts
  task automatic test_random_traffic(int unsigned n);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned k;
    int unsigned m;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      tx_calm <= ($urandom_range(0, 5) == 0);
      rx_calm <= ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        k = $urandom_range(1, 20);
        for (int unsigned i = 0; i < k; i++)
          offer_entry((i == k - 1) || ($urandom_range(0, 9) == 0));
        m = $urandom_range(0, k + 2);
        repeat (m) mark_head();
      end else if (kind <= 7) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          if ($urandom_range(0, 1))
            issue_op(wdq_pkg::OP_OFFER, $urandom, wdq_pkg::TAG_W'($urandom),
                     1'($urandom));
          else
            issue_op(wdq_pkg::OP_MARK, $urandom_range(0, shadow_wm),
                     wdq_pkg::TAG_W'($urandom), 1'($urandom));
        end
      end else begin
        k = $urandom_range(10, 24);
        for (int unsigned i = 0; i < k; i++)
          offer_entry(i == k - 1);
        m = $urandom_range(1, 8);
        repeat (m) mark_head();
      end
    end
  endtask

  // Output held off while input keeps coming, so the block backs up
  task automatic test_output_backpressure();
    hold_tog <= ~hold_tog;
    tx_calm  <= 1'b1;
    for (int unsigned i = 0; i < 30; i++) begin
      if (i % 5 == 4) mark_head();
      else offer_entry(i % 10 == 9);
    end
    tx_calm <= 1'b0;
  endtask

  // Watermark pushed to the top: everything after is stale
  task automatic test_watermark_ceiling();
    issue_op(wdq_pkg::OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    issue_op(wdq_pkg::OP_MARK,  32'hFFFF_FFFF, 16'h0000, 1'b0);
    issue_op(wdq_pkg::OP_OFFER, 32'hFFFF_FFFF, 16'h0F0F, 1'b1);
    issue_op(wdq_pkg::OP_OFFER, 32'h0000_0000, 16'hF0F0, 1'b0);
    issue_op(wdq_pkg::OP_MARK,  32'h0000_0000, 16'hFFFF, 1'b1);
  endtask

  initial begin
    err_cnt       = 0;
    sent_cnt      = 0;
    checked_cnt   = 0;
    cycle_cnt     = 0;
    epoch_cursor  = 32'd600;
    shadow_head   = 0;
    shadow_fill   = 0;
    shadow_wm     = '0;
    shadow_closed = 1'b0;
    for (int unsigned i = 0; i < QD; i++) begin
      shadow_epoch[i] = '0;
      shadow_tag[i]   = '0;
    end
    for (int unsigned i = 0; i < 6; i++) status_hits[i] = 0;
    tx_calm  <= 1'b0;
    rx_calm  <= 1'b0;
    hold_tog <= 1'b0;
    rst_ni   <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.opcode        <= wdq_pkg::OP_OFFER;
    in_if.item_epoch    <= '0;
    in_if.item_tag      <= '0;
    in_if.last_in_batch <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_full_and_batch_close();
    test_compaction();
    test_random_traffic(650);
    test_output_backpressure();
    test_random_traffic(650);
    test_watermark_ceiling();

    // drain
    in_if.valid <= 1'b0;
    while (awaited_outcomes.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d operations, checked %0d results.", sent_cnt, checked_cnt);
    $display("Status mix: queued %0d stale %0d dup %0d full %0d closed %0d marked %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (err_cnt == 0 && awaited_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/wdq_pkg.sv
src/wdq_if.sv
src/wdq_store.sv
src/watermark_dedup_queue.sv
bench/tb_watermark_dedup_queue.sv
